FILE: rtl/dhpi_pkg.sv
`default_nettype none
package dhpi_pkg;

   // Channel count and index width.
   localparam int NCH  = 2;
   localparam int CH_W = 1;

   // Field widths fixed by the interface.
   localparam int TEMP_W  = 16;
   localparam int PGAIN_W = 18;
   localparam int IGAIN_W = 17;
   localparam int FF_W    = 17;
   localparam int OUT_W   = 17;

   // Internal arithmetic widths.
   localparam int ERR_W     = 17;  // setpoint minus sample, signed Q8.8
   localparam int ACC_W     = 24;  // clamped integrator, signed Q24
   localparam int SUM_W     = 38;  // duty and integrator sums before clamping
   localparam int DUTY_FRAC = 24;  // Q24 duty: 1.0 = 1 << 24
   localparam int MA_W      = 25;  // shared multiplier, operand A

   localparam int INTEG_LIMIT = 1 << 22;

   // Sample kind codes.
   localparam logic [1:0] KIND_NONE      = 2'd0;
   localparam logic [1:0] KIND_VALID     = 2'd1;
   localparam logic [1:0] KIND_NONFINITE = 2'd2;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN_0    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN_1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN_0   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN_1   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDFWD_DUTY_0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDFWD_DUTY_1 = 3'd7;

   // Register reset values.
   localparam logic [TEMP_W-1:0]  RST_TARGET_TEMP  = 16'd14080;
   localparam logic [PGAIN_W-1:0] RST_PROP_GAIN    = 18'd65536;
   localparam logic [IGAIN_W-1:0] RST_INTEG_GAIN   = 17'd1638;
   localparam logic [FF_W-1:0]    RST_FEEDFWD_DUTY = 17'd3277;

   typedef struct packed {
      logic [NCH-1:0][TEMP_W-1:0]  target_temp;
      logic [NCH-1:0][PGAIN_W-1:0] prop_gain;
      logic [NCH-1:0][IGAIN_W-1:0] integ_gain;
      logic [NCH-1:0][FF_W-1:0]    feedfwd_duty;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               sample_kind_0;
      logic signed [TEMP_W-1:0] sample_temp_0;
      logic [1:0]               sample_kind_1;
      logic signed [TEMP_W-1:0] sample_temp_1;
   } req_type;

   typedef struct packed {
      logic             heater_level_0;
      logic             heater_level_1;
      logic [OUT_W-1:0] on_time_us_0;
      logic [OUT_W-1:0] on_time_us_1;
      logic             at_target_0;
      logic             at_target_1;
      logic [OUT_W-1:0] next_delay_us;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/dual_heater_pi_time_proportioning.sv
// Each channel takes the short path through CHAN alone when its heater is on or it has no
//   usable sample, and the PI path from CHAN to ONTIME otherwise; DELAY and FINISH follow.
// Transactions run one at a time through the single shared multiplier, which serves
//   the integral, proportional and on-time products of both channels in turn.
// Reset: synchronous, active high; heaters off, integrators, on-times and flags cleared,
//   configuration registers loaded with their default values.
`default_nettype none
module dual_heater_pi_time_proportioning
   import dhpi_pkg::*;
#(
   parameter int PERIOD_US    = 100000,
   parameter int TARGET_BAND  = 640,
   parameter int MIN_DELAY_US = 1000
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Width of on-time values and of the period itself.
   localparam int PW   = $clog2(PERIOD_US + 1);
   localparam int MW   = $clog2(MIN_DELAY_US + 1);
   localparam int DW   = (PW > MW) ? PW : MW;
   // Operand B carries a gain (up to 18 bits) or the period, always as a positive value.
   localparam int MB_W = (PW + 1 > PGAIN_W + 1) ? PW + 1 : PGAIN_W + 1;
   localparam int MP_W = MA_W + MB_W;

   localparam logic [PW-1:0]           PERIOD   = PW'(PERIOD_US);
   localparam logic signed [SUM_W-1:0] LIM_SUM  = SUM_W'(INTEG_LIMIT);
   localparam logic signed [ACC_W-1:0] LIM_ACC  = ACC_W'(INTEG_LIMIT);

   // The sequencer walks channel 0 and then channel 1. For a channel that runs the loop:
   // CHAN forms the error, MUL_I issues error times integral gain, ACC updates the clamped
   // integrator and issues error times proportional gain, SUM forms the Q24 duty, MUL_T
   // issues duty times period and ONTIME stores the on-time, the band flag and the heater.
   // DELAY then scans both channels for the shortest remainder, and FINISH loads the
   // result register once it is free.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHAN,
      S_MUL_I,
      S_ACC,
      S_SUM,
      S_MUL_T,
      S_ONTIME,
      S_DELAY,
      S_FINISH
   } state_type;

   cfg_type cfg;

   state_type             state_ff, state_in;
   logic [CH_W-1:0]       ch_ff, ch_in;
   req_type               req_ff, req_in;

   logic                  heater_ff [NCH];
   logic                  heater_in [NCH];
   logic signed [ACC_W-1:0] acc_ff [NCH];
   logic signed [ACC_W-1:0] acc_in [NCH];
   logic [PW-1:0]         ot_ff [NCH];
   logic [PW-1:0]         ot_in [NCH];
   logic                  tgt_ff [NCH];
   logic                  tgt_in [NCH];

   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [DUTY_FRAC-1:0]  duty_ff, duty_in;
   logic                  duty_pos_ff, duty_pos_in;
   logic                  duty_big_ff, duty_big_in;
   logic                  near_ff, near_in;
   logic [PW-1:0]         next_ff, next_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Shared multiplier.
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] prod;

   // Per-channel views selected by the channel counter.
   logic [1:0]               smp_kind;
   logic signed [TEMP_W-1:0] smp_temp;
   logic signed [TEMP_W-1:0] set_temp;
   logic signed [ERR_W-1:0]  err_calc;
   logic signed [SUM_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  acc_clamp;
   logic signed [SUM_W-1:0]  duty_sum;
   logic [ERR_W-1:0]         err_mag;
   logic [PW-1:0]            ot_calc;
   logic [PW-1:0]            delay_cand;
   logic [DW-1:0]            delay_out;
   logic                     ch_last;

   dhpi_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dhpi_mul #(
      .A_W (MA_W),
      .B_W (MB_W)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign ch_last  = (ch_ff == CH_W'(NCH - 1));
   assign smp_kind = ch_ff ? req_ff.sample_kind_1 : req_ff.sample_kind_0;
   assign smp_temp = ch_ff ? req_ff.sample_temp_1 : req_ff.sample_temp_0;
   assign set_temp = $signed(cfg.target_temp[ch_ff]);
   assign err_calc = ERR_W'(set_temp) - ERR_W'(smp_temp);

   // Operand selection: the gains and the period are always positive, so they are
   // zero-extended; the error is sign-extended and the duty is known to be positive.
   always_comb begin
      case (state_ff)
         S_MUL_I: begin
            mul_a = MA_W'(err_ff);
            mul_b = MB_W'(cfg.integ_gain[ch_ff]);
         end
         S_MUL_T: begin
            mul_a = MA_W'(duty_ff);
            mul_b = MB_W'(PERIOD);
         end
         default: begin
            mul_a = MA_W'(err_ff);
            mul_b = MB_W'(cfg.prop_gain[ch_ff]);
         end
      endcase
   end

   // Integrator update, clamped to plus or minus one quarter of full duty.
   assign acc_sum = SUM_W'(acc_ff[ch_ff]) + SUM_W'(prod);
   always_comb begin
      if (acc_sum > LIM_SUM) begin
         acc_clamp = LIM_ACC;
      end else if (acc_sum < -LIM_SUM) begin
         acc_clamp = -LIM_ACC;
      end else begin
         acc_clamp = ACC_W'(acc_sum);
      end
   end

   // Q24 duty: feedforward raised from Q16, plus the proportional term and the integrator.
   assign duty_sum = SUM_W'($signed({1'b0, cfg.feedfwd_duty[ch_ff], 8'd0}))
                   + SUM_W'(prod) + SUM_W'(acc_ff[ch_ff]);

   assign err_mag = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);

   // A duty of one or more always clamps to the full period, so the multiplier's product
   // is used only for a duty below one, and then never exceeds the period.
   always_comb begin
      if (!duty_pos_ff) begin
         ot_calc = '0;
      end else if (duty_big_ff) begin
         ot_calc = PERIOD;
      end else begin
         ot_calc = prod[DUTY_FRAC +: PW];
      end
   end

   // Remaining time of the channel under the scan: on-time while the heater is on,
   // otherwise the rest of the period.
   assign delay_cand = heater_ff[ch_ff] ? ot_ff[ch_ff] : PERIOD - ot_ff[ch_ff];
   assign delay_out  = (DW'(next_ff) < DW'(MIN_DELAY_US)) ? DW'(MIN_DELAY_US) : DW'(next_ff);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      req_in       = req_ff;
      heater_in    = heater_ff;
      acc_in       = acc_ff;
      ot_in        = ot_ff;
      tgt_in       = tgt_ff;
      err_in       = err_ff;
      duty_in      = duty_ff;
      duty_pos_in  = duty_pos_ff;
      duty_big_in  = duty_big_ff;
      near_in      = near_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               ch_in    = '0;
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            err_in = err_calc;
            if (heater_ff[ch_ff] || smp_kind != KIND_VALID) begin
               // A heater that is on is switched off and the sample is dropped; a missing
               // or non-finite sample leaves the channel as it is.
               heater_in[ch_ff] = 1'b0;
               if (ch_last) begin
                  ch_in    = '0;
                  next_in  = PERIOD;
                  state_in = S_DELAY;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end else begin
               state_in = S_MUL_I;
            end
         end
         S_MUL_I: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in[ch_ff] = acc_clamp;
            state_in      = S_SUM;
         end
         S_SUM: begin
            duty_in     = duty_sum[DUTY_FRAC-1:0];
            duty_pos_in = !duty_sum[SUM_W-1] && (|duty_sum);
            duty_big_in = !duty_sum[SUM_W-1] && (|duty_sum[SUM_W-2:DUTY_FRAC]);
            near_in     = ({1'b0, err_mag} < (ERR_W + 1)'(TARGET_BAND));
            state_in    = S_MUL_T;
         end
         S_MUL_T: begin
            state_in = S_ONTIME;
         end
         S_ONTIME: begin
            ot_in[ch_ff]     = ot_calc;
            tgt_in[ch_ff]    = near_ff;
            heater_in[ch_ff] = (ot_calc != '0);
            if (ch_last) begin
               ch_in    = '0;
               next_in  = PERIOD;
               state_in = S_DELAY;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_CHAN;
            end
         end
         S_DELAY: begin
            if (delay_cand != '0 && delay_cand < next_ff) begin
               next_in = delay_cand;
            end
            if (ch_last) begin
               ch_in    = '0;
               state_in = S_FINISH;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         S_FINISH: begin
            // Wait here only while an earlier result has not been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.heater_level_0  = heater_ff[0];
               rsp_data_in.heater_level_1  = heater_ff[1];
               rsp_data_in.on_time_us_0    = OUT_W'(ot_ff[0]);
               rsp_data_in.on_time_us_1    = OUT_W'(ot_ff[1]);
               rsp_data_in.at_target_0     = tgt_ff[0];
               rsp_data_in.at_target_1     = tgt_ff[1];
               rsp_data_in.next_delay_us   = OUT_W'(delay_out);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCH; c++) begin
            heater_ff[c] <= 1'b0;
            acc_ff[c]    <= '0;
            ot_ff[c]     <= '0;
            tgt_ff[c]    <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         heater_ff    <= heater_in;
         acc_ff       <= acc_in;
         ot_ff        <= ot_in;
         tgt_ff       <= tgt_in;
      end
      req_ff      <= req_in;
      err_ff      <= err_in;
      duty_ff     <= duty_in;
      duty_pos_ff <= duty_pos_in;
      duty_big_ff <= duty_big_in;
      near_ff     <= near_in;
      next_ff     <= next_in;
      rsp_data_ff <= rsp_data_in;
   end

   // New transactions are taken only between items; a finished result may still be
   // waiting in the output register while the next one is accepted.
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The integrator never leaves its clamp range.
   a_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      acc_ff[0] <= LIM_ACC && acc_ff[0] >= -LIM_ACC &&
      acc_ff[1] <= LIM_ACC && acc_ff[1] >= -LIM_ACC)
      else $error("integrator outside clamp range");

   // Held on-times never exceed the period.
   a_ot_bounded: assert property (@(posedge clock) disable iff (reset)
      ot_ff[0] <= PERIOD && ot_ff[1] <= PERIOD)
      else $error("on-time above period");

   // A heater is only on with a nonzero on-time behind it.
   a_heater_ot: assert property (@(posedge clock) disable iff (reset)
      (heater_ff[0] |-> ot_ff[0] != '0) and (heater_ff[1] |-> ot_ff[1] != '0))
      else $error("heater on with zero on-time");

   // An accepted transaction always starts its walk at channel 0.
   a_start_ch0: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_CHAN && ch_ff == '0)
      else $error("sequencer did not start at channel 0");
`endif

endmodule
`default_nettype wire

FILE: rtl/dhpi_csr.sv
`default_nettype none
module dhpi_csr
   import dhpi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            cfg_ff.target_temp[c]  <= RST_TARGET_TEMP;
            cfg_ff.prop_gain[c]    <= RST_PROP_GAIN;
            cfg_ff.integ_gain[c]   <= RST_INTEG_GAIN;
            cfg_ff.feedfwd_duty[c] <= RST_FEEDFWD_DUTY;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TARGET_TEMP_0:  cfg_ff.target_temp[0]  <= csr_wdata[TEMP_W-1:0];
            CSR_TARGET_TEMP_1:  cfg_ff.target_temp[1]  <= csr_wdata[TEMP_W-1:0];
            CSR_PROP_GAIN_0:    cfg_ff.prop_gain[0]    <= csr_wdata[PGAIN_W-1:0];
            CSR_PROP_GAIN_1:    cfg_ff.prop_gain[1]    <= csr_wdata[PGAIN_W-1:0];
            CSR_INTEG_GAIN_0:   cfg_ff.integ_gain[0]   <= csr_wdata[IGAIN_W-1:0];
            CSR_INTEG_GAIN_1:   cfg_ff.integ_gain[1]   <= csr_wdata[IGAIN_W-1:0];
            CSR_FEEDFWD_DUTY_0: cfg_ff.feedfwd_duty[0] <= csr_wdata[FF_W-1:0];
            CSR_FEEDFWD_DUTY_1: cfg_ff.feedfwd_duty[1] <= csr_wdata[FF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: rtl/dhpi_mul.sv
`default_nettype none
module dhpi_mul #(
   parameter int A_W = 25,
   parameter int B_W = 21
) (
   input  wire logic                    clock,
   input  wire logic signed [A_W-1:0]   op_a,
   input  wire logic signed [B_W-1:0]   op_b,
   output logic signed [A_W+B_W-1:0]    prod
);

   // Product is registered so the consumer sees it in the cycle after issue.
   logic signed [A_W+B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

FILE: tb/tb_dual_heater_pi_time_proportioning.sv
`timescale 1ns / 100ps

module tb_dual_heater_pi_time_proportioning;
   import dhpi_pkg::*;

   // Block parameters; the instance below is built with the same values so the
   // predictor and the hardware agree on the period, band and minimum delay.
   localparam int PERIOD_US    = 100000;
   localparam int TARGET_BAND  = 640;
   localparam int MIN_DELAY_US = 1000;

   // The one kind code the package leaves unnamed. The block treats it like no sample.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int NREG            = 8;
   localparam int PHASES          = 9;
   localparam int TICKS_PER_PHASE = 126;
   localparam int LONG_STALL      = 300;   // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES   = 20;    // above the worst-case latency
   localparam int QUIET_LIMIT     = 3000;  // cycles without any transaction

   localparam logic [CSR_IDX_W-1:0] REG_ORDER [NREG] = '{
      CSR_TARGET_TEMP_0, CSR_TARGET_TEMP_1, CSR_PROP_GAIN_0, CSR_PROP_GAIN_1,
      CSR_INTEG_GAIN_0, CSR_INTEG_GAIN_1, CSR_FEEDFWD_DUTY_0, CSR_FEEDFWD_DUTY_1
   };

   // How a whole register set is chosen for one phase.
   typedef enum int {
      CFG_HIGH, CFG_LOW, CFG_SPREAD, CFG_MIXED, CFG_RAW, CFG_DEFAULT
   } cfg_style_e;

   localparam cfg_style_e PHASE_STYLE [PHASES] = '{
      CFG_HIGH, CFG_LOW, CFG_MIXED, CFG_RAW, CFG_DEFAULT,
      CFG_MIXED, CFG_HIGH, CFG_RAW, CFG_SPREAD
   };

   // The scoreboard carries its own copy of the registers and of the per-channel
   // controller state. Every accepted tick advances that copy and queues the
   // result that the block has to return for it; results come back in order.
   class heater_tick_predictor;
      logic signed [TEMP_W-1:0] setpoint [NCH];
      logic [PGAIN_W-1:0]       kp [NCH];
      logic [IGAIN_W-1:0]       ki [NCH];
      logic [FF_W-1:0]          ff [NCH];
      bit                       heating [NCH];
      longint                   integ [NCH];
      longint                   on_us [NCH];
      bit                       in_band [NCH];
      rsp_type                  expected_ticks [$];
      int unsigned              failures;

      function new();
         for (int c = 0; c < NCH; c++) begin
            setpoint[c] = RST_TARGET_TEMP;
            kp[c]       = RST_PROP_GAIN;
            ki[c]       = RST_INTEG_GAIN;
            ff[c]       = RST_FEEDFWD_DUTY;
            heating[c]  = 1'b0;
            integ[c]    = 0;
            on_us[c]    = 0;
            in_band[c]  = 1'b0;
         end
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_TARGET_TEMP_0:  setpoint[0] = value[TEMP_W-1:0];
            CSR_TARGET_TEMP_1:  setpoint[1] = value[TEMP_W-1:0];
            CSR_PROP_GAIN_0:    kp[0] = value[PGAIN_W-1:0];
            CSR_PROP_GAIN_1:    kp[1] = value[PGAIN_W-1:0];
            CSR_INTEG_GAIN_0:   ki[0] = value[IGAIN_W-1:0];
            CSR_INTEG_GAIN_1:   ki[1] = value[IGAIN_W-1:0];
            CSR_FEEDFWD_DUTY_0: ff[0] = value[FF_W-1:0];
            CSR_FEEDFWD_DUTY_1: ff[1] = value[FF_W-1:0];
            default: ;
         endcase
      endfunction

      // One channel of one tick. A heater that is on is simply switched off.
      function void run_channel(int c, logic [1:0] kind, logic signed [TEMP_W-1:0] temp);
         longint err;
         longint duty;
         longint ot;
         if (heating[c]) begin
            heating[c] = 1'b0;
            return;
         end
         if (kind != KIND_VALID) return;
         err = longint'(setpoint[c]) - longint'(temp);
         integ[c] += err * longint'(ki[c]);
         if (integ[c] > INTEG_LIMIT) integ[c] = INTEG_LIMIT;
         if (integ[c] < -INTEG_LIMIT) integ[c] = -INTEG_LIMIT;
         duty = longint'(ff[c]) * 256 + err * longint'(kp[c]) + integ[c];
         if (duty <= 0) begin
            ot = 0;
         end else begin
            ot = (duty * PERIOD_US) >>> DUTY_FRAC;
            if (ot > PERIOD_US) ot = PERIOD_US;
         end
         on_us[c] = ot;
         in_band[c] = ((err < 0) ? -err : err) < TARGET_BAND;
         if (ot > 0) heating[c] = 1'b1;
      endfunction

      function void note_tick(req_type t);
         rsp_type r;
         longint  next;
         longint  d;
         run_channel(0, t.sample_kind_0, t.sample_temp_0);
         run_channel(1, t.sample_kind_1, t.sample_temp_1);
         next = PERIOD_US;
         for (int c = 0; c < NCH; c++) begin
            d = heating[c] ? on_us[c] : PERIOD_US - on_us[c];
            if (d > 0 && d < next) next = d;
         end
         if (next < MIN_DELAY_US) next = MIN_DELAY_US;
         r.heater_level_0 = heating[0];
         r.heater_level_1 = heating[1];
         r.on_time_us_0   = OUT_W'(on_us[0]);
         r.on_time_us_1   = OUT_W'(on_us[1]);
         r.at_target_0    = in_band[0];
         r.at_target_1    = in_band[1];
         r.next_delay_us  = OUT_W'(next);
         expected_ticks.push_back(r);
      endfunction

      function int field_diff(string name, longint want, longint got);
         if (want == got) return 0;
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      endfunction

      function void check_tick(rsp_type got);
         rsp_type want;
         if (expected_ticks.size() == 0) begin
            $error("result %h arrived with no tick outstanding", got);
            failures++;
            return;
         end
         want = expected_ticks.pop_front();
         failures += field_diff("heater_level_0", want.heater_level_0, got.heater_level_0);
         failures += field_diff("heater_level_1", want.heater_level_1, got.heater_level_1);
         failures += field_diff("on_time_us_0", want.on_time_us_0, got.on_time_us_0);
         failures += field_diff("on_time_us_1", want.on_time_us_1, got.on_time_us_1);
         failures += field_diff("at_target_0", want.at_target_0, got.at_target_0);
         failures += field_diff("at_target_1", want.at_target_1, got.at_target_1);
         failures += field_diff("next_delay_us", want.next_delay_us, got.next_delay_us);
      endfunction
   endclass

   // All block inputs start at known values through their initializers.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heater_tick_predictor ticks = new();

   // Idle rates in percent, changed by the main sequence between phases.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   // Set by the main sequence; the receiver picks it up and runs its own hold-off.
   bit          long_stall_pending = 1'b0;

   dual_heater_pi_time_proportioning #(
      .PERIOD_US   (PERIOD_US),
      .TARGET_BAND (TARGET_BAND),
      .MIN_DELAY_US(MIN_DELAY_US)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic req_type tick_of(logic [1:0] k0, int t0, logic [1:0] k1, int t1);
      req_type t;
      t.sample_kind_0 = k0;
      t.sample_temp_0 = 16'(t0);
      t.sample_kind_1 = k1;
      t.sample_temp_1 = 16'(t1);
      return t;
   endfunction

   // Random tick. Most samples are valid, and almost half of the temperatures sit
   // near the current setpoint so that the integrator winds both ways, hits its
   // clamps and the target band gets crossed. The rest spans the sensor range,
   // with a few raw 16-bit patterns outside it.
   function automatic req_type random_tick();
      logic [1:0]               kind [NCH];
      logic signed [TEMP_W-1:0] temp [NCH];
      int unsigned              roll;
      for (int c = 0; c < NCH; c++) begin
         roll = $urandom_range(99);
         if (roll < 70)      kind[c] = KIND_VALID;
         else if (roll < 80) kind[c] = KIND_NONE;
         else if (roll < 90) kind[c] = KIND_NONFINITE;
         else                kind[c] = KIND_UNUSED;
         roll = $urandom_range(99);
         if (roll < 8) begin
            // Just inside or just outside the band, on either side.
            temp[c] = 16'(int'(ticks.setpoint[c])
                          + ($urandom_range(1) ? 1 : -1)
                          * (TARGET_BAND - 1 + int'($urandom_range(1))));
         end else if (roll < 48) begin
            temp[c] = 16'(int'(ticks.setpoint[c]) + int'($urandom_range(2048)) - 1024);
         end else if (roll < 90) begin
            temp[c] = 16'(int'($urandom_range(40960)) - 10240);
         end else begin
            temp[c] = 16'($urandom);
         end
      end
      return tick_of(kind[0], temp[0], kind[1], temp[1]);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(logic [CSR_IDX_W-1:0] idx,
                                                       cfg_style_e style);
      int lo;
      int hi;
      int rst;
      case (idx)
         CSR_TARGET_TEMP_0, CSR_TARGET_TEMP_1: begin
            lo = -10240; hi = 30720; rst = RST_TARGET_TEMP;
         end
         CSR_PROP_GAIN_0, CSR_PROP_GAIN_1: begin
            lo = 0; hi = 131072; rst = RST_PROP_GAIN;
         end
         CSR_INTEG_GAIN_0, CSR_INTEG_GAIN_1: begin
            lo = 0; hi = 65536; rst = RST_INTEG_GAIN;
         end
         default: begin
            lo = 0; hi = 65536; rst = RST_FEEDFWD_DUTY;
         end
      endcase
      // A mixed set takes each register independently from one of the first three styles.
      if (style == CFG_MIXED) style = cfg_style_e'($urandom_range(2));
      case (style)
         CFG_HIGH:   return CSR_DATA_W'(hi);
         CFG_LOW:    return CSR_DATA_W'(lo);
         CFG_SPREAD: return CSR_DATA_W'(lo + int'($urandom_range(hi - lo)));
         CFG_RAW:    return CSR_DATA_W'($urandom);
         default:    return CSR_DATA_W'(rst);
      endcase
   endfunction

   // Writes the whole register set on back-to-back cycles. The write enable stays
   // high across the burst and is dropped once at the end.
   task automatic program_registers(input cfg_style_e style);
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i < NREG; i++) begin
         value = reg_value(REG_ORDER[i], style);
         csr_write_en <= 1'b1;
         csr_index    <= REG_ORDER[i];
         csr_wdata    <= value;
         @(posedge clock);
         ticks.write_reg(REG_ORDER[i], value);
      end
      csr_write_en <= 1'b0;
   endtask

   // Offers one tick and returns at the edge where it is accepted. An idle gap,
   // when one is drawn, drops valid and puts noise on the payload; otherwise valid
   // stays high straight into the next transaction.
   task automatic send_tick(input req_type t);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'({$urandom, $urandom});
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      ticks.note_tick(t);
   endtask

   // Every tick yields a result, so once the queue is empty the block is idle.
   // The extra wait keeps register writes well clear of the last handshake.
   task automatic wait_drained();
      while (ticks.expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: checks each accepted transaction and draws the next ready level.
   // A long hold-off, when requested, is counted here so that the sender keeps
   // offering ticks while the block sits on a finished result with its input stalled.
   initial begin : result_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) ticks.check_tick(rsp_data);
         if (long_stall_pending) begin
            hold_left = LONG_STALL;
            long_stall_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $error("no transaction for %0d cycles", QUIET_LIMIT);
      $display("tb_dual_heater_pi_time_proportioning: FAIL");
      $finish;
   end

   initial begin : main_sequence
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset register values (setpoint 55 degrees).
      // Each valid sample that switches a heater on is followed by a tick that
      // finds the heater on and must switch it off while ignoring its sample.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_tick(tick_of(KIND_NONE, 0, KIND_NONE, 0));
      send_tick(tick_of(KIND_VALID, 14080, KIND_NONFINITE, 0));        // zero error
      send_tick(tick_of(KIND_VALID, -10240, KIND_VALID, 14080));
      send_tick(tick_of(KIND_VALID, -10240, KIND_VALID, 30720));       // full on-time
      send_tick(tick_of(KIND_VALID, 0, KIND_VALID, 30720));            // negative duty
      send_tick(tick_of(KIND_VALID, 30720, KIND_VALID, -10240));
      send_tick(tick_of(KIND_NONFINITE, 14080, KIND_UNUSED, 14080));
      send_tick(tick_of(KIND_UNUSED, 16'h7FFF, KIND_VALID, 16'h8000)); // out of range
      send_tick(tick_of(KIND_VALID, 16'h8000, KIND_VALID, 16'h7FFF));
      send_tick(tick_of(KIND_VALID, 14080 + 639, KIND_VALID, 14080 - 639));
      send_tick(tick_of(KIND_VALID, 14080 + 640, KIND_VALID, 14080 - 640));
      send_tick(tick_of(KIND_VALID, 14080 - 640, KIND_VALID, 14080 + 640));
      send_tick(tick_of(KIND_VALID, 16'hFFFF, KIND_NONE, 16'hFFFF));
      send_tick(tick_of(KIND_NONFINITE, 16'h5555, KIND_VALID, 16'hAAAA));
      req_valid <= 1'b0;

      // Random phases, each under its own register set. The receiver idles more in
      // the first third, the sender in the second, and neither in the last.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         program_registers(PHASE_STYLE[p]);
         if (p < 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 47;
         end else if (p < 6) begin
            req_idle_pct = 47;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p == 1 || p == 6) long_stall_pending = 1'b1;
         repeat (TICKS_PER_PHASE) send_tick(random_tick());
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ticks.failures == 0 && ticks.expected_ticks.size() == 0) begin
         $display("tb_dual_heater_pi_time_proportioning: PASS");
      end else begin
         $display("tb_dual_heater_pi_time_proportioning: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/dhpi_pkg.sv
rtl/dhpi_csr.sv
rtl/dhpi_mul.sv
rtl/dual_heater_pi_time_proportioning.sv
tb/tb_dual_heater_pi_time_proportioning.sv
